// ===== hdl/upq_pkg.sv =====
`timescale 1ns / 1ps

package upq_pkg;

   // Command codes
   localparam logic [1:0] CMD_ENQ  = 2'd0;
   localparam logic [1:0] CMD_DEQ  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] item_priority;
      logic [15:0]        item_tag;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] found_priority;
      logic [15:0]        found_tag;
      logic               is_empty;
   } rsp_item_type;

   // One table entry
   typedef struct packed {
      logic signed [31:0] prio;
      logic [15:0]        tag;
   } entry_type;

endpackage

// ===== hdl/unsorted_priority_queue.sv =====
`timescale 1ns / 1ps

// Bounded priority queue of up to DEPTH entries held in arrival order in a
// single-port-read table. An enqueue appends at the tail. A dequeue or peek
// scans the held entries with one signed comparator, one table read per
// cycle; a dequeue then closes the gap by moving each later entry down one
// slot, one per cycle through the same read port. Ties go to the earliest
// entry (strict compare). The input side is stalled while an item is at
// work; a finished result sits in an output register, so the next item is
// taken while it waits. Empty and full are reported in the status field;
// command 3 is a no-op that returns ok.

module unsorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  upq_pkg::req_item_type  req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output upq_pkg::rsp_item_type  rsp_item
);
   import upq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] cur_ff, cur_in;        // index of the entry on the read port
   logic [AW-1:0] best_idx_ff, best_idx_in;
   entry_type     best_ff, best_in;      // best so far; zero when nothing found
   logic          is_deq_ff, is_deq_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;

   logic [CW-1:0] last_idx;
   logic [CW-1:0] nxt_idx;
   logic          take;
   logic          at_last;

   upq_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign last_idx = count_ff - CW'(1);
   assign at_last  = (CW'(cur_ff) == last_idx);
   // first entry always seeds the best; later ones only on strictly greater
   assign take     = (cur_ff == '0) || (rd_data.prio > best_ff.prio);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      is_deq_in    = is_deq_ff;
      status_in    = status_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data.prio = req_item.item_priority;
      wr_data.tag  = req_item.item_tag;
      rd_addr      = '0;
      nxt_idx      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               best_in   = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               case (req_item.cmd)
                  CMD_ENQ: begin
                     if (count_ff < CW'(DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  CMD_DEQ, CMD_PEEK: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_addr   = '0;
                        cur_in    = '0;
                        is_deq_in = (req_item.cmd == CMD_DEQ);
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     // unused command: no change
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (take) begin
               best_in     = rd_data;
               best_idx_in = cur_ff;
            end
            if (at_last) begin
               if (!is_deq_ff) begin
                  state_in = S_DONE;
               end else begin
                  nxt_idx = CW'(best_idx_in) + CW'(1);
                  if (nxt_idx < count_ff) begin
                     rd_addr  = nxt_idx[AW-1:0];
                     cur_in   = nxt_idx[AW-1:0];
                     state_in = S_SHIFT;
                  end else begin
                     // winner was the tail entry: nothing to move
                     count_in = count_ff - CW'(1);
                     state_in = S_DONE;
                  end
               end
            end else begin
               rd_addr = cur_ff + AW'(1);
               cur_in  = cur_ff + AW'(1);
            end
         end

         S_SHIFT: begin
            // move the entry on the read port down one slot
            wr_en   = 1'b1;
            wr_addr = cur_ff - AW'(1);
            wr_data = rd_data;
            if (at_last) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               rd_addr = cur_ff + AW'(1);
               cur_in  = cur_ff + AW'(1);
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_item_in.status         = status_ff;
               rsp_item_in.found_priority = best_ff.prio;
               rsp_item_in.found_tag      = best_ff.tag;
               rsp_item_in.is_empty       = (count_ff == '0);
               state_in                   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      is_deq_ff   <= is_deq_in;
      status_ff   <= status_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// ===== hdl/upq_store.sv =====
`timescale 1ns / 1ps

module upq_store #(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  upq_pkg::entry_type             wr_data,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output upq_pkg::entry_type             rd_data
);
   import upq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
